[hw/rtl/bda_pkg.sv]
`default_nettype none

package bda_pkg;

    localparam int VALUE_W    = 64;
    localparam int CHAR_W     = 8;
    localparam int MAX_DIGITS = 20;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int LEFT_W     = $clog2(MAX_DIGITS + 1);

    localparam logic [CHAR_W-1:0] ZERO_CODE = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] NL_CODE   = CHAR_W'(10);

    // packed decimal result handed from the converter to the emitter
    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             ovf;
    } bda_result_t;

endpackage

`default_nettype wire

[hw/rtl/bda_conv.sv]
`default_nettype none

module bda_conv (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bda_pkg::VALUE_W-1:0]   in_value,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output bda_pkg::bda_result_t               res
);
    import bda_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_DONE = 3'b100
    } conv_state_t;

    conv_state_t        state_reg, state_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               ovf_reg, ovf_next;
    logic [BCD_W-1:0]   adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb begin
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (bcd_reg[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end else begin
                adj[d*DIGIT_W +: DIGIT_W] = bcd_reg[d*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            C_IDLE: begin
                if (in_valid) begin
                    bin_next   = in_value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = C_RUN;
                end
            end
            C_RUN: begin
                // a bit leaving the top digit means more digits than the buffer holds
                ovf_next = ovf_reg | adj[BCD_W-1];
                bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_W - 1)) begin
                    state_next = C_DONE;
                end
            end
            C_DONE: begin
                if (res_ready) begin
                    state_next = C_IDLE;
                end
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            state_reg <= state_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        ovf_reg <= ovf_next;
    end

    assign in_ready  = (state_reg == C_IDLE);
    assign res_valid = (state_reg == C_DONE);
    assign res.bcd   = bcd_reg;
    assign res.ovf   = ovf_reg;

endmodule

`default_nettype wire

[hw/rtl/bda_emit.sv]
`default_nettype none

module bda_emit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          res_valid,
    output logic                               res_ready,
    input  wire bda_pkg::bda_result_t          res,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [bda_pkg::CHAR_W-1:0]         out_char,
    output logic                               out_last
);
    import bda_pkg::*;

    typedef enum logic [3:0] {
        E_IDLE  = 4'b0001,
        E_SKIP  = 4'b0010,
        E_DIGIT = 4'b0100,
        E_NL    = 4'b1000
    } emit_state_t;

    emit_state_t       state_reg, state_next;
    logic [BCD_W-1:0]  dig_reg, dig_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic              ov_reg, ov_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic              slot_free;
    logic [DIGIT_W-1:0] top;

    assign top       = dig_reg[BCD_W-1 -: DIGIT_W];
    assign slot_free = !ov_reg || out_ready;

    always_comb begin
        state_next = state_reg;
        dig_next   = dig_reg;
        left_next  = left_reg;
        ov_next    = ov_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            E_IDLE: begin
                if (res_valid) begin
                    dig_next   = res.bcd;
                    left_next  = LEFT_W'(MAX_DIGITS);
                    // overflowed values keep every buffered digit, zeros included
                    state_next = res.ovf ? E_DIGIT : E_SKIP;
                end
            end
            E_SKIP: begin
                if (top == '0 && left_reg != LEFT_W'(1)) begin
                    dig_next  = {dig_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                end else begin
                    state_next = E_DIGIT;
                end
            end
            E_DIGIT: begin
                if (slot_free) begin
                    ov_next   = 1'b1;
                    char_next = ZERO_CODE + CHAR_W'(top);
                    last_next = 1'b0;
                    dig_next  = {dig_reg[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    left_next = left_reg - LEFT_W'(1);
                    if (left_reg == LEFT_W'(1)) begin
                        state_next = E_NL;
                    end
                end
            end
            E_NL: begin
                if (slot_free) begin
                    ov_next    = 1'b1;
                    char_next  = NL_CODE;
                    last_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        dig_reg  <= dig_next;
        left_reg <= left_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign res_ready = (state_reg == E_IDLE);
    assign out_valid = ov_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

[hw/rtl/binary_to_decimal_ascii.sv]
// Converts an unsigned 64-bit value to decimal ASCII text, most significant digit first with
// no leading zeros (zero gives a single '0'), followed by a newline (10) that carries m_last.
// A double-dabble converter shifts the value in one bit per cycle after s_value is accepted,
// then hands the packed digits to the emitter from its hand-off state.
// The emitter loads them, skips leading zero digits one at a time, finds the first digit to
// send, and sends one character at a time, digits plus the newline (2 to 21), as m_ready allows.
// The converter takes the next request while the emitter still sends the previous text, so
// back-to-back requests each pass through the converter's shift state, its hand-off state and
// its accept state. Only a character side that stalls for long lets the emitter fall behind and
// hold the converter in its hand-off state. m_valid comes straight from an output register.
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request side
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [bda_pkg::VALUE_W-1:0]   s_value,
    // character side
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bda_pkg::CHAR_W-1:0]         m_character,
    output logic                               m_last
);
    import bda_pkg::*;

    // packed decimal hand-off between the two halves
    bda_result_t res;
    logic        res_valid;
    logic        res_ready;

    // bit-serial shift-add-3 binary to packed decimal
    bda_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // digit-serial emitter: drops leading zeros, sends ascii digits and the newline
    bda_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_char  (m_character),
        .out_last  (m_last)
    );

endmodule

`default_nettype wire
